### rtl/core/lmlt_pkg.sv
`default_nettype none
package lmlt_pkg;

    // payload of one input transfer
    typedef struct packed {
        logic               kind;
        logic [15:0]        range_mm;
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
        logic               last_beam;
    } lmlt_in_t;

    // payload of one result transfer
    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] pos_x_mm;
        logic signed [15:0] pos_y_mm;
        logic [9:0]         person_count;
        logic               goal_valid;
        logic               last;
    } lmlt_out_t;

    typedef enum logic [2:0] {
        CFG_MOTION_THRESHOLD = 3'd0,
        CFG_GAP_THRESHOLD    = 3'd1,
        CFG_MOVING_SHARE     = 3'd2,
        CFG_LEG_MIN          = 3'd3,
        CFG_LEG_MAX          = 3'd4,
        CFG_PAIR_DISTANCE    = 3'd5,
        CFG_RANGE_LIMIT      = 3'd6,
        CFG_SETTLE_SCANS     = 3'd7
    } lmlt_cfg_e;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } lmlt_op_e;

    // command to the shared root / divide unit
    typedef struct packed {
        logic     start;
        lmlt_op_e op;
    } lmlt_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_GAP_SQX,
        ST_GAP_SQY,
        ST_GAP_GO,
        ST_GAP_WAIT,
        ST_CLOSE,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_PAIR_SQX,
        ST_PAIR_SQY,
        ST_PAIR_GO,
        ST_PAIR_WAIT,
        ST_PERSON,
        ST_LEG_DONE,
        ST_FINISH,
        ST_SUMMARY
    } lmlt_state_e;

    localparam logic KIND_BEAM   = 1'b0;
    localparam logic KIND_GOAL   = 1'b1;
    localparam logic RES_PERSON  = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    localparam logic [9:0]  PERSONS_MAX = 10'd1023;
    localparam logic [10:0] POINTS_MAX  = 11'd2047;
    localparam logic [4:0]  SQRT_STEPS  = 5'd17;
    localparam logic [4:0]  DIV_STEPS   = 5'd27;

endpackage
`default_nettype wire

### rtl/core/lmlt_root_div.sv
`default_nettype none
module lmlt_root_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lmlt_pkg::lmlt_cmd_t cmd,
    input  wire logic [33:0]        opa,
    input  wire logic [10:0]        divisor,
    output logic                    busy,
    output logic [26:0]             result
);
    import lmlt_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    lmlt_op_e    op_reg;
    logic [33:0] acc_reg;
    logic [19:0] rem_reg;
    logic [26:0] q_reg;
    logic [10:0] div_reg;

    logic [19:0] rem_sh;
    logic [19:0] trial;
    logic        fits;

    // one restoring step: two radicand bits for a root, one dividend bit for a quotient
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            rem_sh = {rem_reg[17:0], acc_reg[33:32]};
            trial  = {q_reg[17:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[18:0], acc_reg[33]};
            trial  = {9'd0, div_reg};
        end
        fits = (rem_sh >= trial);
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = (cmd.op == OP_DIV) ? DIV_STEPS : SQRT_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= cmd.op;
            acc_reg <= (cmd.op == OP_DIV) ? {opa[26:0], 7'd0} : opa;
            rem_reg <= '0;
            q_reg   <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= (op_reg == OP_SQRT) ? {acc_reg[31:0], 2'b00} : {acc_reg[32:0], 1'b0};
            rem_reg <= fits ? (rem_sh - trial) : rem_sh;
            q_reg   <= {q_reg[25:0], fits};
        end
    end

    assign busy   = busy_reg;
    assign result = q_reg;

endmodule
`default_nettype wire

### rtl/core/lidar_moving_leg_tracker_core.sv
`default_nettype none
// moving-leg tracker for a streamed lidar scan. beams come in one transfer at a time;
// each range is clamped, judged against a banked background and grouped into clusters,
// leg clusters are paired into persons and the last beam of a scan yields a summary.
// a goal event forces background relearning and produces no result. one item is
// handled at a time: a beam needs no distance while learning or when no cluster is
// open, one 17-step square root on the shared root/divide unit for the gap when it
// extends or closes a cluster, and, when it closes a leg cluster, also two 27-step
// divisions for the centre and, if a partner leg waits, a second root for the pairing
// distance. a last beam closes its cluster without the gap root and adds the summary,
// and any waiting on result stall comes on top. the background memory has one write
// and one registered read port and needs no clearing after reset.
module lidar_moving_leg_tracker_core #(
    parameter int BEAMS = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire lmlt_pkg::lmlt_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output lmlt_pkg::lmlt_out_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import lmlt_pkg::*;

    localparam int IDX_W     = $clog2(BEAMS);
    localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

    // configuration registers
    logic [15:0] motion_thr_reg, gap_thr_reg, leg_min_reg, leg_max_reg;
    logic [15:0] pair_dist_reg, range_limit_reg;
    logic [6:0]  share_pct_reg;
    logic [7:0]  settle_scans_reg;

    lmlt_state_e state_reg, state_next;

    // scan and cluster state
    logic             active_bank_reg, active_bank_next;
    logic [IDX_W-1:0] beam_cnt_reg, beam_cnt_next;
    logic             learn_reg, learn_next;
    logic [7:0]       settle_reg, settle_next;
    logic signed [15:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [27:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [10:0]      points_reg, points_next, moving_cnt_reg, moving_cnt_next;
    logic [15:0]      length_reg, length_next;
    logic signed [15:0] leg_x_reg, leg_x_next, leg_y_reg, leg_y_next;
    logic             leg_valid_reg, leg_valid_next;
    logic [9:0]       persons_reg, persons_next;
    logic signed [15:0] last_px_reg, last_px_next, last_py_reg, last_py_next;

    // per item working registers
    lmlt_in_t         item_reg, item_next;
    logic [15:0]      r_clamp_reg, r_clamp_next;
    logic             moving_reg, moving_next;
    logic             add_pend_reg, add_pend_next;
    logic [33:0]      sq_acc_reg, sq_acc_next;
    logic signed [15:0] cx_reg, cx_next, cy_reg, cy_next;

    // result register
    logic      out_valid_reg, out_valid_next;
    lmlt_out_t out_reg, out_next;
    logic      out_load;
    logic      slot_free;

    // background memory
    logic [15:0]      bg_mem [MEM_DEPTH];
    logic [15:0]      bg_rd_reg;
    logic             bg_we;

    // shared unit
    lmlt_cmd_t   unit_cmd;
    logic [33:0] unit_opa;
    logic        unit_busy;
    logic [26:0] unit_res;

    // datapath helpers
    logic signed [16:0] mul_a;
    logic signed [33:0] prod;
    logic [15:0]        bg_diff;
    logic [16:0]        dist_res;
    logic [17:0]        len_sum;
    logic [17:0]        moving_scaled, share_scaled;
    logic               is_leg;
    logic [26:0]        abs_x, abs_y;
    logic [16:0]        qmag, qsigned;
    logic signed [16:0] mid_x, mid_y;
    logic               in_xfer;

    assign in_xfer   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_thr_reg   <= 16'd150;
            gap_thr_reg      <= 16'd150;
            share_pct_reg    <= 7'd80;
            leg_min_reg      <= 16'd30;
            leg_max_reg      <= 16'd200;
            pair_dist_reg    <= 16'd25000;
            range_limit_reg  <= 16'd5000;
            settle_scans_reg <= 8'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MOTION_THRESHOLD: motion_thr_reg   <= cfg_data;
                CFG_GAP_THRESHOLD:    gap_thr_reg      <= cfg_data;
                CFG_MOVING_SHARE:     share_pct_reg    <= cfg_data[6:0];
                CFG_LEG_MIN:          leg_min_reg      <= cfg_data;
                CFG_LEG_MAX:          leg_max_reg      <= cfg_data;
                CFG_PAIR_DISTANCE:    pair_dist_reg    <= cfg_data;
                CFG_RANGE_LIMIT:      range_limit_reg  <= cfg_data;
                CFG_SETTLE_SCANS:     settle_scans_reg <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // background banks: read the active bank, write the inactive one
    assign bg_we = (state_reg == ST_LOOKUP);

    always_ff @(posedge clk)
    begin
        if (bg_we)
            bg_mem[{~active_bank_reg, beam_cnt_reg}] <= r_clamp_reg;
        bg_rd_reg <= bg_mem[{active_bank_reg, beam_cnt_reg}];
    end

    // single multiplier for the squared differences
    always_comb
    begin
        unique case (state_reg)
            ST_GAP_SQX:  mul_a = 17'(item_reg.x_mm) - 17'(prev_x_reg);
            ST_GAP_SQY:  mul_a = 17'(item_reg.y_mm) - 17'(prev_y_reg);
            ST_PAIR_SQX: mul_a = 17'(cx_reg) - 17'(leg_x_reg);
            default:     mul_a = 17'(cy_reg) - 17'(leg_y_reg);
        endcase
    end
    assign prod = mul_a * mul_a;

    assign bg_diff  = (r_clamp_reg > bg_rd_reg) ? (r_clamp_reg - bg_rd_reg)
                                                : (bg_rd_reg - r_clamp_reg);
    assign dist_res = unit_res[16:0];
    assign len_sum  = {2'b00, length_reg} + {1'b0, dist_res};

    // moving*100 >= pct*points and length inside the leg window
    assign moving_scaled = {7'd0, moving_cnt_reg} * 18'd100;
    assign share_scaled  = {11'd0, share_pct_reg} * {7'd0, points_reg};
    assign is_leg = (moving_scaled >= share_scaled)
                 && (length_reg >= leg_min_reg) && (length_reg <= leg_max_reg);

    assign abs_x = sum_x_reg[27] ? 27'(-sum_x_reg) : sum_x_reg[26:0];
    assign abs_y = sum_y_reg[27] ? 27'(-sum_y_reg) : sum_y_reg[26:0];

    // quotient truncated toward zero, sign taken from the sum being divided
    always_comb
    begin
        qmag = unit_res[16:0];
        if (state_reg == ST_DIVX_WAIT)
            qsigned = sum_x_reg[27] ? (17'd0 - qmag) : qmag;
        else
            qsigned = sum_y_reg[27] ? (17'd0 - qmag) : qmag;
    end

    // midpoint rounds toward minus infinity
    assign mid_x = 17'(cx_reg) + 17'(leg_x_reg);
    assign mid_y = 17'(cy_reg) + 17'(leg_y_reg);

    // unit commands
    always_comb
    begin
        unit_cmd.start = 1'b0;
        unit_cmd.op    = OP_SQRT;
        unit_opa       = sq_acc_reg;
        unique case (state_reg)
            ST_GAP_GO, ST_PAIR_GO:
            begin
                unit_cmd.start = 1'b1;
            end
            ST_DIVX_GO:
            begin
                unit_cmd.start = 1'b1;
                unit_cmd.op    = OP_DIV;
                unit_opa       = {7'd0, abs_x};
            end
            ST_DIVY_GO:
            begin
                unit_cmd.start = 1'b1;
                unit_cmd.op    = OP_DIV;
                unit_opa       = {7'd0, abs_y};
            end
            default: ;
        endcase
    end

    lmlt_root_div u_root_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (unit_cmd),
        .opa     (unit_opa),
        .divisor (points_reg),
        .busy    (unit_busy),
        .result  (unit_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer && in_data.kind == KIND_BEAM)
                    state_next = ST_LOOKUP;
            ST_LOOKUP:
                if (learn_reg)
                    state_next = ST_FINISH;
                else if (item_reg.last_beam)
                    state_next = ST_CLOSE;
                else if (points_reg == 11'd0)
                    state_next = ST_FINISH;
                else
                    state_next = ST_GAP_SQX;
            ST_GAP_SQX:  state_next = ST_GAP_SQY;
            ST_GAP_SQY:  state_next = ST_GAP_GO;
            ST_GAP_GO:   state_next = ST_GAP_WAIT;
            ST_GAP_WAIT:
                if (!unit_busy)
                    state_next = (dist_res > {1'b0, gap_thr_reg}) ? ST_CLOSE : ST_FINISH;
            ST_CLOSE:
                if (points_reg == 11'd0)
                    state_next = ST_FINISH;
                else if (is_leg)
                    state_next = ST_DIVX_GO;
                else
                    state_next = ST_LEG_DONE;
            ST_DIVX_GO:  state_next = ST_DIVX_WAIT;
            ST_DIVX_WAIT:
                if (!unit_busy)
                    state_next = ST_DIVY_GO;
            ST_DIVY_GO:  state_next = ST_DIVY_WAIT;
            ST_DIVY_WAIT:
                if (!unit_busy)
                    state_next = leg_valid_reg ? ST_PAIR_SQX : ST_LEG_DONE;
            ST_PAIR_SQX: state_next = ST_PAIR_SQY;
            ST_PAIR_SQY: state_next = ST_PAIR_GO;
            ST_PAIR_GO:  state_next = ST_PAIR_WAIT;
            ST_PAIR_WAIT:
                if (!unit_busy)
                    state_next = (dist_res < {1'b0, pair_dist_reg}) ? ST_PERSON : ST_LEG_DONE;
            ST_PERSON:
                if (slot_free)
                    state_next = ST_LEG_DONE;
            ST_LEG_DONE: state_next = ST_FINISH;
            ST_FINISH:
                state_next = item_reg.last_beam ? ST_SUMMARY : ST_IDLE;
            ST_SUMMARY:
                if (slot_free)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        active_bank_next = active_bank_reg;
        beam_cnt_next    = beam_cnt_reg;
        learn_next       = learn_reg;
        settle_next      = settle_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        sum_x_next       = sum_x_reg;
        sum_y_next       = sum_y_reg;
        points_next      = points_reg;
        moving_cnt_next  = moving_cnt_reg;
        length_next      = length_reg;
        leg_x_next       = leg_x_reg;
        leg_y_next       = leg_y_reg;
        leg_valid_next   = leg_valid_reg;
        persons_next     = persons_reg;
        last_px_next     = last_px_reg;
        last_py_next     = last_py_reg;
        item_next        = item_reg;
        r_clamp_next     = r_clamp_reg;
        moving_next      = moving_reg;
        add_pend_next    = add_pend_reg;
        sq_acc_next      = sq_acc_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        out_load         = 1'b0;
        out_next         = out_reg;

        unique case (state_reg)
            ST_IDLE:
                if (in_xfer)
                begin
                    item_next     = in_data;
                    r_clamp_next  = (in_data.range_mm > range_limit_reg) ? range_limit_reg
                                                                          : in_data.range_mm;
                    add_pend_next = 1'b0;
                    if (in_data.kind == KIND_GOAL)
                    begin
                        // goal reached: abandon the scan and relearn
                        learn_next      = 1'b1;
                        settle_next     = '0;
                        sum_x_next      = '0;
                        sum_y_next      = '0;
                        points_next     = '0;
                        moving_cnt_next = '0;
                        length_next     = '0;
                        beam_cnt_next   = '0;
                        prev_x_next     = '0;
                        prev_y_next     = '0;
                        leg_x_next      = '0;
                        leg_y_next      = '0;
                        leg_valid_next  = 1'b0;
                        persons_next    = '0;
                        last_px_next    = '0;
                        last_py_next    = '0;
                    end
                end
            ST_LOOKUP:
            begin
                moving_next = (bg_diff > motion_thr_reg);
                if (!learn_reg && !item_reg.last_beam && points_reg == 11'd0)
                    add_pend_next = 1'b1;
            end
            ST_GAP_SQX: sq_acc_next = 34'(prod);
            ST_GAP_SQY: sq_acc_next = sq_acc_reg + 34'(prod);
            ST_GAP_WAIT:
                if (!unit_busy)
                begin
                    add_pend_next = 1'b1;
                    if (dist_res <= {1'b0, gap_thr_reg})
                        length_next = (len_sum > 18'd65535) ? 16'hFFFF : len_sum[15:0];
                end
            ST_DIVX_WAIT:
                if (!unit_busy)
                    cx_next = qsigned[15:0];
            ST_DIVY_WAIT:
                if (!unit_busy)
                    cy_next = qsigned[15:0];
            ST_PAIR_SQX: sq_acc_next = 34'(prod);
            ST_PAIR_SQY: sq_acc_next = sq_acc_reg + 34'(prod);
            ST_PERSON:
                if (slot_free)
                begin
                    out_load              = 1'b1;
                    out_next.result_kind  = RES_PERSON;
                    out_next.pos_x_mm     = mid_x[16:1];
                    out_next.pos_y_mm     = mid_y[16:1];
                    out_next.person_count = '0;
                    out_next.goal_valid   = 1'b0;
                    out_next.last         = !item_reg.last_beam;
                    if (persons_reg != PERSONS_MAX)
                        persons_next = persons_reg + 10'd1;
                    last_px_next = mid_x[16:1];
                    last_py_next = mid_y[16:1];
                end
            ST_LEG_DONE:
            begin
                // a leg becomes the partner candidate; the cluster is closed either way
                if (is_leg)
                begin
                    leg_x_next     = cx_reg;
                    leg_y_next     = cy_reg;
                    leg_valid_next = 1'b1;
                end
                sum_x_next      = '0;
                sum_y_next      = '0;
                points_next     = '0;
                moving_cnt_next = '0;
                length_next     = '0;
            end
            ST_FINISH:
            begin
                if (add_pend_reg && points_reg != POINTS_MAX)
                begin
                    sum_x_next  = sum_x_reg + 28'(item_reg.x_mm);
                    sum_y_next  = sum_y_reg + 28'(item_reg.y_mm);
                    points_next = points_reg + 11'd1;
                    if (moving_reg)
                        moving_cnt_next = moving_cnt_reg + 11'd1;
                end
                prev_x_next   = item_reg.x_mm;
                prev_y_next   = item_reg.y_mm;
                beam_cnt_next = (beam_cnt_reg == IDX_W'(BEAMS - 1)) ? '0
                                                                   : beam_cnt_reg + 1'b1;
            end
            ST_SUMMARY:
                if (slot_free)
                begin
                    out_load              = 1'b1;
                    out_next.result_kind  = RES_SUMMARY;
                    out_next.pos_x_mm     = '0;
                    out_next.pos_y_mm     = '0;
                    out_next.person_count = learn_reg ? 10'd0 : persons_reg;
                    out_next.goal_valid   = 1'b0;
                    out_next.last         = 1'b1;
                    if (learn_reg)
                    begin
                        // learning scan done: switch to the freshly written bank
                        active_bank_next = ~active_bank_reg;
                        learn_next       = 1'b0;
                    end
                    else if (persons_reg == 10'd1)
                    begin
                        if (settle_reg < settle_scans_reg)
                        begin
                            settle_next      = settle_reg + 8'd1;
                            active_bank_next = ~active_bank_reg;
                        end
                        else
                        begin
                            out_next.goal_valid = 1'b1;
                            out_next.pos_x_mm   = last_px_reg;
                            out_next.pos_y_mm   = last_py_reg;
                        end
                    end
                    sum_x_next      = '0;
                    sum_y_next      = '0;
                    points_next     = '0;
                    moving_cnt_next = '0;
                    length_next     = '0;
                    beam_cnt_next   = '0;
                    prev_x_next     = '0;
                    prev_y_next     = '0;
                    leg_x_next      = '0;
                    leg_y_next      = '0;
                    leg_valid_next  = 1'b0;
                    persons_next    = '0;
                    last_px_next    = '0;
                    last_py_next    = '0;
                end
            default: ;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_bank_reg <= 1'b0;
            beam_cnt_reg    <= '0;
            learn_reg       <= 1'b1;
            settle_reg      <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            points_reg      <= '0;
            moving_cnt_reg  <= '0;
            length_reg      <= '0;
            leg_x_reg       <= '0;
            leg_y_reg       <= '0;
            leg_valid_reg   <= 1'b0;
            persons_reg     <= '0;
            last_px_reg     <= '0;
            last_py_reg     <= '0;
            add_pend_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            active_bank_reg <= active_bank_next;
            beam_cnt_reg    <= beam_cnt_next;
            learn_reg       <= learn_next;
            settle_reg      <= settle_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            sum_x_reg       <= sum_x_next;
            sum_y_reg       <= sum_y_next;
            points_reg      <= points_next;
            moving_cnt_reg  <= moving_cnt_next;
            length_reg      <= length_next;
            leg_x_reg       <= leg_x_next;
            leg_y_reg       <= leg_y_next;
            leg_valid_reg   <= leg_valid_next;
            persons_reg     <= persons_next;
            last_px_reg     <= last_px_next;
            last_py_reg     <= last_py_next;
            add_pend_reg    <= add_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // per item payload
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        r_clamp_reg <= r_clamp_next;
        moving_reg  <= moving_next;
        sq_acc_reg  <= sq_acc_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        out_reg     <= out_next;
    end

    // the shared unit is only launched when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_cmd.start |-> !unit_busy)
        else $error("root/divide unit launched while busy");

    // a result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result register overwritten");

    // a learning scan never counts persons
    assert property (@(posedge clk) disable iff (!rst_n)
        learn_reg |-> (persons_reg == 10'd0) && !leg_valid_reg)
        else $error("person state while learning");

    // a summary transfer leaves a clean scan behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUMMARY) && slot_free |=>
            (beam_cnt_reg == '0) && (points_reg == 11'd0) && (state_reg == ST_IDLE))
        else $error("scan not cleared after summary");

endmodule
`default_nettype wire
